@@ sv/sgm_pkg.sv @@
package sgm_pkg;

    localparam int PIXEL_W = 8;
    localparam int CFG_W   = 16;
    localparam int WIDTH_W = 12;
    localparam int HEIGHT_W = 16;
    localparam int GRAD_W  = 11;   // |gx|,|gy| <= 1020
    localparam int SQ_W    = 21;   // gx^2+gy^2 <= 2080800

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the accepted pixel and window step
        logic emit;       // the accepted pixel completes an interior window
        logic last;       // that window is the last one of the frame
        logic sqrt_start; // start the square root on the captured sums
        logic sqrt_step;  // one iteration of the square root
    } sgm_cmd_t;

    typedef struct packed {
        logic sqrt_done;
    } sgm_stat_t;

endpackage

@@ sv/sgm_ctrl.sv @@
module sgm_ctrl #(
    parameter int COL_W = 11
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pixel_valid,
    output logic                     pixel_ready,
    input  logic                     out_busy,
    input  logic [COL_W-1:0]         last_col,
    input  logic [15:0]              last_row,
    input  logic                     restart,
    input  sgm_pkg::sgm_stat_t       stat,
    output sgm_pkg::sgm_cmd_t        cmd,
    output logic [COL_W-1:0]         col,
    output logic [COL_W-1:0]         rd_col
);
    import sgm_pkg::*;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_ROOT = 1'b1;

    logic [0:0]       state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [15:0]      row_reg, row_next;
    logic             accept, interior;
    logic [COL_W-1:0] c_eff;
    logic [15:0]      r_eff;

    assign pixel_ready = (state_reg == ST_IDLE);
    assign accept      = pixel_valid && pixel_ready;
    assign c_eff       = (col_reg > last_col) ? last_col : col_reg;
    assign r_eff       = (row_reg > last_row) ? last_row : row_reg;
    assign interior    = (r_eff >= 16'd2) && (c_eff >= COL_W'(2));
    assign col         = c_eff;
    // The line stores are read ahead, at the column of the next pixel.
    assign rd_col      = col_next;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    cmd.emit = interior;
                    cmd.last = (r_eff == last_row) && (c_eff == last_col);
                    if (interior)
                        state_next = ST_ROOT;
                    if (c_eff == last_col)
                    begin
                        col_next = '0;
                        row_next = (r_eff == last_row) ? 16'd0 : r_eff + 16'd1;
                    end
                    else
                    begin
                        col_next = c_eff + COL_W'(1);
                        row_next = r_eff;
                    end
                end
            end
            ST_ROOT:
            begin
                // The last step writes the output register, so it waits
                // until the previous result has left.
                if (stat.sqrt_done)
                begin
                    if (!out_busy)
                    begin
                        cmd.sqrt_step = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.sqrt_step = 1'b1;
                end
            end
        endcase
        cmd.sqrt_start = (state_reg == ST_IDLE) && accept && interior;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= last_col)
        else $error("column out of range");
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_start_enters_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_start |=> state_reg == ST_ROOT)
        else $error("square root not started");

endmodule

@@ sv/sgm_datapath.sv @@
module sgm_datapath #(
    parameter int MAX_WIDTH = 2048,
    parameter int COL_W = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sgm_pkg::sgm_cmd_t   cmd,
    output sgm_pkg::sgm_stat_t  stat,
    input  logic [COL_W-1:0]    col,
    input  logic [COL_W-1:0]    rd_col,
    input  logic [7:0]          pixel,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          magnitude,
    output logic                frame_end
);
    import sgm_pkg::*;

    logic [7:0] upper_mem [MAX_WIDTH];
    logic [7:0] middle_mem [MAX_WIDTH];
    logic [7:0] win_reg [6];
    logic [7:0] top_reg, mid_reg;
    logic signed [GRAD_W:0] gx, gy;
    logic [GRAD_W-1:0] ax, ay;
    logic [SQ_W-1:0] sq_reg, rem_reg;
    logic [11:0] res_reg, bit_reg;
    logic [GRAD_W-1:0] ax_reg, ay_reg;
    logic [1:0] phase_reg;
    logic out_valid_reg, last_reg, pend_last_reg;
    logic [7:0] mag_reg;
    logic [SQ_W-1:0] cand;
    logic done;

    // Line stores: registered read of the next pixel's column, so the data
    // for the current column is ready when the pixel is accepted. The write
    // address differs from the read address of the same cycle, except when a restart coincides.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            upper_mem[col]  <= mid_reg;
            middle_mem[col] <= pixel;
        end
        top_reg <= upper_mem[rd_col];
        mid_reg <= middle_mem[rd_col];
    end

    always_comb
    begin
        gx = ($signed({4'd0, top_reg}) - $signed({4'd0, win_reg[0]}))
           + 12'sd2 * ($signed({4'd0, mid_reg}) - $signed({4'd0, win_reg[1]}))
           + ($signed({4'd0, pixel}) - $signed({4'd0, win_reg[2]}));
        gy = ($signed({4'd0, win_reg[2]}) + 12'sd2 * $signed({4'd0, win_reg[5]})
           + $signed({4'd0, pixel}))
           - ($signed({4'd0, win_reg[0]}) + 12'sd2 * $signed({4'd0, win_reg[3]})
           + $signed({4'd0, top_reg}));
        ax = gx[GRAD_W] ? GRAD_W'(-gx) : gx[GRAD_W-1:0];
        ay = gy[GRAD_W] ? GRAD_W'(-gy) : gy[GRAD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (cmd.load)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_reg;
            win_reg[4] <= mid_reg;
            win_reg[5] <= pixel;
        end
    end

    // Square root: phase 0 squares ax, phase 1 adds the square of ay,
    // phase 2 loads the remainder, then one result bit per cycle
    // (restoring, on bit weight b).
    always_comb
    begin
        cand = (SQ_W'(res_reg) << 1) * SQ_W'(bit_reg) + SQ_W'(bit_reg) * SQ_W'(bit_reg);
    end

    assign done = (phase_reg == 2'd3) && (bit_reg == 12'd0);
    assign stat.sqrt_done = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            res_reg       <= '0;
            bit_reg       <= '0;
            sq_reg        <= '0;
            rem_reg       <= '0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            mag_reg       <= '0;
        end
        else
        begin
            if (cmd.sqrt_step && done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.sqrt_start)
            begin
                ax_reg        <= ax;
                ay_reg        <= ay;
                pend_last_reg <= cmd.last;
                phase_reg     <= 2'd0;
            end
            else if (cmd.sqrt_step)
            begin
                unique case (phase_reg)
                    2'd0:
                    begin
                        sq_reg    <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
                        phase_reg <= 2'd1;
                    end
                    2'd1:
                    begin
                        sq_reg    <= sq_reg + SQ_W'(ay_reg) * SQ_W'(ay_reg);
                        res_reg   <= '0;
                        bit_reg   <= 12'd1024;
                        phase_reg <= 2'd2;
                    end
                    2'd2:
                    begin
                        rem_reg   <= sq_reg;
                        phase_reg <= 2'd3;
                    end
                    default:
                    begin
                        if (bit_reg != 12'd0)
                        begin
                            if (rem_reg >= cand)
                            begin
                                rem_reg <= rem_reg - cand;
                                res_reg <= res_reg | bit_reg;
                            end
                            bit_reg <= bit_reg >> 1;
                        end
                        else
                        begin
                            mag_reg   <= (res_reg > 12'd255) ? 8'd255 : res_reg[7:0];
                            last_reg  <= pend_last_reg;
                            phase_reg <= 2'd0;
                        end
                    end
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign magnitude = mag_reg;
    assign frame_end = last_reg;

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> out_valid)
        else $error("result not presented");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(magnitude) && $stable(frame_end))
        else $error("result changed while waiting");

endmodule

@@ sv/sobel_gradient_magnitude.sv @@
// Sobel gradient magnitude over a raster stream of 8-bit pixels.
// Pixels enter on pixel/pixel_valid/pixel_ready, one item per handshake.
// Results leave on magnitude/frame_end with out_valid/out_ready; only
// interior centre pixels give a result, which is computed once the pixel one
// row below and one column right of that centre is accepted.
// A pixel that yields a result is handled in steps: the accepting cycle,
// squaring gx, adding the square of gy, loading the remainder, the
// bit-serial square root and writing the output register; no new pixel
// is accepted until these are done. Along the borders, while no square
// root runs, pixels pass at one item per cycle.
// If the receiver stalls, the result is held in the output register and
// border pixels still pass; the next result waits in its last cycle, with
// no new pixel accepted, until the output register is free.
// Reset clears the position counters and the window; the line stores are
// not cleared, their stale contents never reach a result.
// A configuration write (index 0 width, 1 height) restarts the frame.
module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [7:0]  pixel,
    input  logic        pixel_valid,
    output logic        pixel_ready,
    output logic [7:0]  magnitude,
    output logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready
);
    import sgm_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]    last_col, col, rd_col;
    logic [15:0]         last_row;
    logic                cfg_write;
    sgm_cmd_t            cmd;
    sgm_stat_t           stat;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(640);
            height_reg <= HEIGHT_W'(480);
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_WIDTH)
                width_reg <= cfg_data[WIDTH_W-1:0];
            else
                height_reg <= cfg_data;
        end
    end

    // Effective width and height clamp to the supported range.
    always_comb
    begin
        if (width_reg < WIDTH_W'(3))
            last_col = COL_W'(2);
        else if (32'(width_reg) > MAX_WIDTH)
            last_col = COL_W'(MAX_WIDTH - 1);
        else
            last_col = COL_W'(width_reg - WIDTH_W'(1));
        last_row = (height_reg < 16'd3) ? 16'd2 : height_reg - 16'd1;
    end

    sgm_ctrl #(.COL_W(COL_W)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .out_busy    (out_valid && !out_ready),
        .last_col    (last_col),
        .last_row    (last_row),
        .restart     (cfg_write),
        .stat        (stat),
        .cmd         (cmd),
        .col         (col),
        .rd_col      (rd_col)
    );

    sgm_datapath #(.MAX_WIDTH(MAX_WIDTH), .COL_W(COL_W)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .col       (col),
        .rd_col    (rd_col),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .magnitude (magnitude),
        .frame_end (frame_end)
    );

endmodule

@@ tb/tb_sobel_gradient_magnitude.sv @@
module tb_sobel_gradient_magnitude;
    import sgm_pkg::*;

    localparam int LINE_DEPTH  = 2048;
    localparam int DRAIN_WAIT  = 48;       // comfortably above the result latency
    localparam int CYCLE_LIMIT = 3000000;

    // One expected result: what the block should show on its result port.
    typedef struct {
        logic [7:0] mag;
        logic       fe;
    } mag_result_t;

    // One row of the directed table. Where typed is set, the expected
    // result is written in by hand; otherwise the predictor supplies it.
    typedef struct {
        logic [7:0] px;
        bit         typed;
        logic [7:0] mag;
        logic       fe;
    } sobel_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic [7:0]  pixel;
    logic        pixel_valid;
    logic        pixel_ready;
    logic [7:0]  magnitude;
    logic        frame_end;
    logic        out_valid;
    logic        out_ready;

    sobel_gradient_magnitude DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel      (pixel),
        .pixel_valid(pixel_valid),
        .pixel_ready(pixel_ready),
        .magnitude  (magnitude),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    // Predictor state: its own copy of the line stores, window, position
    // counters and the two configuration registers.
    logic [7:0]  row_above2 [LINE_DEPTH];
    logic [7:0]  row_above1 [LINE_DEPTH];
    logic [7:0]  win [6];
    int unsigned col_pos;
    int unsigned row_pos;
    logic [11:0] width_reg;
    logic [15:0] height_reg;

    mag_result_t pending_mags[$];
    int          mismatch_count;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    longint      cycle_count;

    always #1 clk = ~clk;

    // Integer square root, built bit by bit from the top.
    function automatic int unsigned isqrt(input int unsigned v);
        int unsigned root;
        int unsigned trial;
        root = 0;
        for (int b = 11; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Advances the predictor by one accepted pixel. Returns 1 and fills res
    // when the pixel completes an interior 3x3 window.
    function automatic bit sobel_predict(input logic [7:0] px, output mag_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int          top;
        int          mid;
        int          gx;
        int          gy;
        int unsigned m;
        bit          hit;
        w = (width_reg < 3) ? 3 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
        h = (height_reg < 3) ? 3 : height_reg;
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        top = row_above2[c];
        mid = row_above1[c];
        row_above2[c] = row_above1[c];
        row_above1[c] = px;
        hit = 0;
        res.mag = '0;
        res.fe  = 1'b0;
        if (r >= 2 && c >= 2) begin
            gx = (top - int'(win[0])) + 2 * (mid - int'(win[1])) + (int'(px) - int'(win[2]));
            gy = (int'(win[2]) + 2 * int'(win[5]) + int'(px))
               - (int'(win[0]) + 2 * int'(win[3]) + top);
            if (gx < 0) gx = -gx;
            if (gy < 0) gy = -gy;
            m = isqrt(gx * gx + gy * gy);
            res.mag = (m > 255) ? 8'd255 : m[7:0];
            res.fe  = (r == h - 1 && c == w - 1);
            hit = 1;
        end
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top[7:0];
        win[4] = mid[7:0];
        win[5] = px;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
        return hit;
    endfunction

    // Offers one pixel and waits for its handshake. The expected result,
    // if any, is queued at the accepting edge; a hand-typed value takes
    // precedence over the predictor's.
    task automatic send_pixel(input logic [7:0] px, input bit typed = 0,
                              input logic [7:0] tmag = '0, input logic tfe = 1'b0);
        mag_result_t res;
        while ($urandom_range(99) < sender_idle_pct) begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel       <= px;
        pixel_valid <= 1'b1;
        do
            @(posedge clk);
        while (!pixel_ready);
        if (sobel_predict(px, res)) begin
            if (typed) begin
                res.mag = tmag;
                res.fe  = tfe;
            end
            pending_mags.push_back(res);
        end
    endtask

    // Lets the block finish everything in flight. Pixels on the border give
    // no result, so an empty queue alone does not prove the block is idle.
    task automatic drain_block();
        pixel_valid <= 1'b0;
        @(posedge clk);
        wait (pending_mags.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Writes one register. Only called while the block is idle. A write
    // restarts the frame, so the predictor's position counters are cleared.
    task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
        drain_block();
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_WIDTH)
            width_reg = data[11:0];
        else
            height_reg = data[15:0];
        col_pos = 0;
        row_pos = 0;
    endtask

    // Random pixel: mostly uniform, with a share of extremes so that large
    // gradients and the saturation at 255 come up often.
    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(3))
            0:       return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            default: return $urandom_range(255);
        endcase
    endfunction

    // Result monitor. Each accepted result is checked against the oldest
    // expectation; the receiver's ready is redrawn every cycle.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_mags.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result magnitude=%0d frame_end=%0d",
                             magnitude, frame_end);
            end else begin
                mag_result_t exp_res;
                exp_res = pending_mags.pop_front();
                if (magnitude !== exp_res.mag || frame_end !== exp_res.fe) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: magnitude exp %0d got %0d, frame_end exp %0d got %0d",
                                 exp_res.mag, magnitude, exp_res.fe, frame_end);
                end
            end
        end
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        sobel_row_t  directed [27];
        int          phase_idle [4];
        int          phase_stall [4];
        int unsigned rw;
        int unsigned rh;

        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_WIDTH;
        cfg_data    = '0;
        pixel       = '0;
        pixel_valid = 1'b0;
        out_ready   = 1'b0;
        mismatch_count     = 0;
        cycle_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        for (int i = 0; i < LINE_DEPTH; i++) begin
            row_above2[i] = '0;
            row_above1[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            win[i] = '0;
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = 12'd640;
        height_reg = 16'd480;

        // Three 3x3 frames: a flat one, a horizontal ramp, a vertical step.
        // The single centre result of each is easy to work out by hand.
        for (int i = 0; i < 9; i++)
            directed[i] = '{8'h00, 0, 8'd0, 1'b0};
        directed[8] = '{8'h00, 1, 8'd0, 1'b1};
        for (int i = 0; i < 9; i++)
            directed[9 + i] = '{(i % 3 == 0) ? 8'h00 : ((i % 3 == 1) ? 8'h80 : 8'hFF),
                                0, 8'd0, 1'b0};
        directed[17] = '{8'hFF, 1, 8'd255, 1'b1};    // |gx| = 1020 saturates
        for (int i = 0; i < 9; i++)
            directed[18 + i] = '{(i < 3) ? 8'hFF : ((i < 6) ? 8'h5A : 8'h00), 0, 8'd0, 1'b0};
        directed[26] = '{8'h00, 1, 8'd255, 1'b1};    // |gy| = 1020 saturates

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Upper bits of the width write fall outside the 12-bit register.
        write_reg(REG_WIDTH, 16'hF003);
        write_reg(REG_HEIGHT, 16'd3);
        foreach (directed[i])
            send_pixel(directed[i].px, directed[i].typed, directed[i].mag, directed[i].fe);

        // Register extremes. A width of zero acts as three, a height of zero
        // acts as three; a tall frame is only started, then abandoned.
        write_reg(REG_WIDTH, 16'd0);
        write_reg(REG_HEIGHT, 16'd0);
        repeat (18) send_pixel(rand_pixel());
        write_reg(REG_WIDTH, 16'd3);
        write_reg(REG_HEIGHT, 16'hFFFF);
        repeat (60) send_pixel(rand_pixel());
        // Widest row: 4095 is clipped to the line store depth; the frame is
        // only started, then abandoned.
        write_reg(REG_WIDTH, 16'd4095);
        write_reg(REG_HEIGHT, 16'd3);
        repeat (40) send_pixel(rand_pixel());

        // Random part in four traffic phases. Each phase picks a fresh frame
        // size, mostly small so that frames and their last results come often.
        phase_idle  = '{0, 80, 0, 11};
        phase_stall = '{0, 0, 80, 11};
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
            rw = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
            rh = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 9);
            write_reg(REG_WIDTH, rw[15:0]);
            write_reg(REG_HEIGHT, rh[15:0]);
            sender_idle_pct    = phase_idle[ph];
            receiver_stall_pct = phase_stall[ph];
            for (int n = 0; n < 320; n++) begin
                send_pixel(rand_pixel());
                // Once per phase, halfway through, the sender holds off until all results are in.
                if (n == 160) begin
                    pixel_valid <= 1'b0;
                    @(posedge clk);
                    wait (pending_mags.size() == 0);
                end
            end
        end

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        drain_block();

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // A queue of expectations that grows without bound means results have
    // stopped coming; it is counted as a failure and cleared.
    always @(posedge clk) begin
        if (rst_n && pending_mags.size() > 4096) begin
            mismatch_count++;
            pending_mags.delete();
        end
    end

endmodule

@@ filelist.f @@
sv/sgm_pkg.sv
sv/sgm_ctrl.sv
sv/sgm_datapath.sv
sv/sobel_gradient_magnitude.sv
tb/tb_sobel_gradient_magnitude.sv
